>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the calibrator RTL.
// Needs a clk and an active-high rst in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Boolean condition must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> hw/rtl/mbc_pkg.sv
// Shared constants and types of the marker-framed bin calibrator.
// No dependencies; used by mbc_table, mbc_div and the top level.
package mbc_pkg;

  localparam int MAX_BINS_DEF = 64;
  localparam int BINS_W       = 7;
  localparam logic [BINS_W-1:0] BINS_RESET = 7'd4;

  localparam int SAMP_W  = 16;
  localparam int COEF_W  = 16;
  localparam int ENTRY_W = 2 * COEF_W;
  localparam int IDX_W   = 6;
  localparam int RES_W   = 32;

  // Divider widths: magnitude <= 2^31, divisor d <= 2^31.
  localparam int MAG_W  = 32;
  localparam int DEN_W  = 32;
  localparam int FRAC_SHIFT = 15;
  localparam int QUO_W  = MAG_W + FRAC_SHIFT;
  localparam int CNT_W  = $clog2(QUO_W + 1);

  localparam logic signed [SAMP_W-1:0] MARK_NEG_ONE = 16'sh8000;
  localparam logic signed [SAMP_W-1:0] MARK_ZERO    = 16'sh0000;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> hw/rtl/mbc_table.sv
// Calibration coefficient memory: one write port, one registered read port.
// Uses mbc_pkg for the entry width.
module mbc_table import mbc_pkg::*; #(
  parameter int MAX_BINS = MAX_BINS_DEF,
  localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [ENTRY_W-1:0] wr_data,
  input  logic [AW-1:0]      rd_addr,
  output logic [ENTRY_W-1:0] rd_data
);

  logic [ENTRY_W-1:0] mem [MAX_BINS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hw/rtl/mbc_div.sv
// Restoring divider, one quotient bit per cycle: q = (mag*2^15 + d) / (2*d).
// Uses mbc_pkg for widths and the status struct; includes assert_macros.svh.
`include "assert_macros.svh"

module mbc_div import mbc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [MAG_W-1:0] mag,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo,
  output div_stat_t        stat
);

  localparam logic [CNT_W-1:0] LAST = CNT_W'(QUO_W - 1);

  logic [QUO_W-1:0] nq;
  logic [DEN_W:0]   rem;
  logic [DEN_W:0]   dvs;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W+1:0] trial;
  logic [DEN_W+1:0] diff;
  logic             fits;

  always_comb begin
    trial = {rem, nq[QUO_W-1]};
    diff  = trial - {1'b0, dvs};
    fits  = !diff[DEN_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else if (start) begin
      stat.busy <= 1'b1;
      stat.done <= 1'b0;
      cnt       <= '0;
    end else begin
      stat.done <= stat.busy && (cnt == LAST);
      if (stat.busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          stat.busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nq  <= {mag, {FRAC_SHIFT{1'b0}}} + QUO_W'(den);
      dvs <= {den, 1'b0};
      rem <= '0;
    end else if (stat.busy) begin
      nq  <= {nq[QUO_W-2:0], fits};
      rem <= fits ? diff[DEN_W:0] : trial[DEN_W:0];
    end
  end

  assign quo = nq;

  `ASSERT_NEVER(a_start_while_busy, start && stat.busy, "divider restarted while busy")
  `ASSERT_NEVER(a_busy_and_done, stat.busy && stat.done, "divider busy and done together")
  `ASSERT_HOLDS(a_done_single, stat.done |=> !stat.done, "divider done held longer than a cycle")

endmodule

>>> hw/rtl/marker_framed_bin_calibrator.sv
// Marker-framed bin calibrator, top level: framing control, multiply-accumulate
// sequencer and result register. Uses mbc_pkg, mbc_table, mbc_div, assert_macros.svh.
//
// Input channel (in_valid / in_stall): kind = 1 writes a calibration coefficient
//   (cal_index, cal_real, cal_imag); kind = 0 carries a sample (sample_real,
//   sample_imag). Idle marker is (0x8000,0x8000), gap marker (0,0x8000). A sweep
//   starts at the first sample that is not an idle marker; from it on, each sample
//   up to bins_in_use bins is divided by the coefficient of its bin and gives one
//   item on the output channel (out_valid / out_stall). Markers give nothing;
//   after bins_in_use bins a marker closes the sweep and an idle marker re-arms it.
// Config channel (cfg_valid / cfg_ready / cfg_data) writes bins_in_use; the user
//   must do so only while idle, which the block itself does not enforce.
// Steps: a calibrated sample goes through 1 table read, 6 steps of the shared
//   16x16 multiply-accumulate, 1 divisor check, two divider passes (47 quotient
//   bits each, one a cycle, plus the done strobe) and the emit step. in_stall
//   stays high meanwhile, so no new item is taken before the result is loaded
//   into the output register. A zero coefficient skips the divider passes.
// A result sits in the output register until taken; a stalled receiver holds the
//   next result back and with it the input. Reset clears framing to idle,
//   bins_in_use to 4 and out_valid; the coefficient table is not cleared.
`include "assert_macros.svh"

module marker_framed_bin_calibrator import mbc_pkg::*; #(
  parameter int MAX_BINS = MAX_BINS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     kind,
  input  logic signed [SAMP_W-1:0] sample_real,
  input  logic signed [SAMP_W-1:0] sample_imag,
  input  logic [IDX_W-1:0]         cal_index,
  input  logic signed [COEF_W-1:0] cal_real,
  input  logic signed [COEF_W-1:0] cal_imag,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [BINS_W-1:0]        cfg_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [RES_W-1:0]  result_real,
  output logic signed [RES_W-1:0]  result_imag,
  output logic [IDX_W-1:0]         bin_number,
  output logic                     overflow_flag
);

  localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int ACC_W = 2 * SAMP_W + 1;

  typedef enum logic [1:0] {P_IDLE, P_RCV, P_DONE} phase_t;
  typedef enum logic [2:0] {S_IDLE, S_READ, S_MAC, S_CHK, S_DIVR, S_DIVI, S_EMIT} seq_t;
  typedef enum logic [2:0] {M_XX, M_YY, M_AX, M_BY, M_BX, M_AY} mac_step_t;

  // Round-to-nearest quotient to a saturated 32-bit part; bit 32 flags saturation.
  function automatic logic [RES_W:0] sat_part(input logic [QUO_W-1:0] q, input logic neg);
    logic [RES_W:0] r;
    if (!neg) begin
      if (q[QUO_W-1:RES_W-1] != '0) r = {1'b1, 1'b0, {(RES_W-1){1'b1}}};
      else r = {1'b0, q[RES_W-1:0]};
    end else begin
      if (q[QUO_W-1:RES_W] != '0 || (q[RES_W-1] && q[RES_W-2:0] != '0)) begin
        r = {1'b1, 1'b1, {(RES_W-1){1'b0}}};
      end else begin
        r = {1'b0, -q[RES_W-1:0]};
      end
    end
    return r;
  endfunction

  // Control state
  phase_t            phase;
  seq_t              state;
  mac_step_t         step;
  logic [BINS_W-1:0] bins_in_use;
  logic [BINS_W-1:0] bin_index;

  // Work registers
  logic signed [SAMP_W-1:0] a_reg;
  logic signed [SAMP_W-1:0] b_reg;
  logic [BINS_W-1:0]        bin_cur;
  logic signed [ACC_W-1:0]  d_acc;
  logic signed [ACC_W-1:0]  nr_acc;
  logic signed [ACC_W-1:0]  ni_acc;
  logic [RES_W-1:0]         res_real;
  logic [RES_W-1:0]         res_imag;
  logic                     res_sat;
  logic                     div_neg;

  // Table and divider
  logic [ENTRY_W-1:0] rd_data;
  logic               tab_wr;
  logic signed [COEF_W-1:0] coef_x;
  logic signed [COEF_W-1:0] coef_y;
  logic [QUO_W-1:0]   quo;
  div_stat_t          div_st;
  logic               div_start;
  logic signed [ACC_W-1:0] num_sel;
  logic signed [ACC_W-1:0] num_abs;
  logic [RES_W:0]     part;

  // Framing decode
  logic              accept;
  logic              idle_mark;
  logic              marker;
  logic [BINS_W-1:0] limit;
  logic [BINS_W-1:0] bin_eff;
  logic              bins_full;
  logic              active;

  // Shared multiplier
  logic signed [SAMP_W-1:0]   op1;
  logic signed [SAMP_W-1:0]   op2;
  logic signed [2*SAMP_W-1:0] prod;
  logic signed [ACC_W-1:0]    prod_ext;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    idle_mark = (sample_real == MARK_NEG_ONE) && (sample_imag == MARK_NEG_ONE);
    marker    = (sample_imag == MARK_NEG_ONE) &&
                (sample_real == MARK_NEG_ONE || sample_real == MARK_ZERO);
    limit     = (32'(bins_in_use) > MAX_BINS) ? BINS_W'(MAX_BINS) : bins_in_use;
    bin_eff   = (phase == P_RCV) ? bin_index : '0;
    bins_full = (bin_eff >= limit);
    active    = (phase == P_RCV) || !idle_mark;
    tab_wr    = accept && kind && (32'(cal_index) < MAX_BINS);
  end

  mbc_table #(.MAX_BINS(MAX_BINS)) u_table (
    .clk     (clk),
    .wr_en   (tab_wr),
    .wr_addr (AW'(cal_index)),
    .wr_data ({cal_real, cal_imag}),
    .rd_addr (AW'(bin_cur)),
    .rd_data (rd_data)
  );

  assign coef_x = rd_data[ENTRY_W-1:COEF_W];
  assign coef_y = rd_data[COEF_W-1:0];

  // Operand select for the six multiply-accumulate steps
  always_comb begin
    unique case (step)
      M_XX:    begin op1 = coef_x; op2 = coef_x; end
      M_YY:    begin op1 = coef_y; op2 = coef_y; end
      M_AX:    begin op1 = a_reg;  op2 = coef_x; end
      M_BY:    begin op1 = b_reg;  op2 = coef_y; end
      M_BX:    begin op1 = b_reg;  op2 = coef_x; end
      M_AY:    begin op1 = a_reg;  op2 = coef_y; end
      default: begin op1 = '0;     op2 = '0;     end
    endcase
    prod     = op1 * op2;
    prod_ext = ACC_W'(prod);
  end

  // Divider feed: real numerator first, imaginary second
  always_comb begin
    num_sel   = (state == S_CHK) ? nr_acc : ni_acc;
    num_abs   = num_sel[ACC_W-1] ? -num_sel : num_sel;
    div_start = ((state == S_CHK) && (d_acc != '0)) || ((state == S_DIVR) && div_st.done);
    part      = sat_part(quo, div_neg);
  end

  mbc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .mag   (num_abs[MAG_W-1:0]),
    .den   (d_acc[DEN_W-1:0]),
    .quo   (quo),
    .stat  (div_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= P_IDLE;
      state       <= S_IDLE;
      step        <= M_XX;
      bins_in_use <= BINS_RESET;
      bin_index   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        bins_in_use <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && !kind) begin
            if (phase == P_DONE) begin
              if (idle_mark) phase <= P_IDLE;
            end else if (active) begin
              bin_index <= bin_eff;
              if (marker) begin
                phase <= bins_full ? P_DONE : P_RCV;
              end else begin
                phase <= P_RCV;
                if (!bins_full) begin
                  // Claim the bin and start the computation
                  bin_index <= bin_eff + 1'b1;
                  bin_cur   <= bin_eff;
                  a_reg     <= sample_real;
                  b_reg     <= sample_imag;
                  state     <= S_READ;
                end
              end
            end
          end
        end
        S_READ: begin
          step  <= M_XX;
          state <= S_MAC;
        end
        S_MAC: begin
          unique case (step)
            M_XX:    begin d_acc  <= prod_ext;          step <= M_YY; end
            M_YY:    begin d_acc  <= d_acc + prod_ext;  step <= M_AX; end
            M_AX:    begin nr_acc <= prod_ext;          step <= M_BY; end
            M_BY:    begin nr_acc <= nr_acc + prod_ext; step <= M_BX; end
            M_BX:    begin ni_acc <= prod_ext;          step <= M_AY; end
            M_AY:    begin ni_acc <= ni_acc - prod_ext; state <= S_CHK; end
            default: step <= M_XX;
          endcase
        end
        S_CHK: begin
          if (d_acc == '0) begin
            res_real <= '0;
            res_imag <= '0;
            res_sat  <= 1'b1;
            state    <= S_EMIT;
          end else begin
            div_neg <= num_sel[ACC_W-1];
            state   <= S_DIVR;
          end
        end
        S_DIVR: begin
          if (div_st.done) begin
            res_real <= part[RES_W-1:0];
            res_sat  <= part[RES_W];
            div_neg  <= num_sel[ACC_W-1];
            state    <= S_DIVI;
          end
        end
        S_DIVI: begin
          if (div_st.done) begin
            res_imag <= part[RES_W-1:0];
            res_sat  <= res_sat | part[RES_W];
            state    <= S_EMIT;
          end
        end
        S_EMIT: begin
          // Load the output register once it is free or being taken
          if (!out_valid || !out_stall) begin
            result_real   <= res_real;
            result_imag   <= res_imag;
            bin_number    <= bin_cur[IDX_W-1:0];
            overflow_flag <= res_sat;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_HOLDS(a_done_in_div, div_st.done |-> (state == S_DIVR || state == S_DIVI),
                "divider finished outside a divide phase")
  `ASSERT_HOLDS(a_load_from_emit, $rose(out_valid) |-> $past(state == S_EMIT),
                "result loaded outside the emit step")
  `ASSERT_HOLDS(a_div_idle_out, (state == S_IDLE) |-> !div_st.busy,
                "divider busy while the block takes items")
  `ASSERT_NEVER(a_bin_write_busy, tab_wr && (state != S_IDLE),
                "table written while an item is in work")

endmodule

>>> tb/testbench.sv
// Self-checking bench for marker_framed_bin_calibrator: directed table plus random sweeps,
// each result checked against its directed expectation or a cycle-free quotient
// predictor kept inside this module. Depends on mbc_pkg and the calibrator RTL only.
module testbench import mbc_pkg::*;;

  localparam int TABLE_DEPTH   = MAX_BINS_DEF;
  localparam int SETTLE_CYCLES = 120;   // settle time for trailing work after a drain
  localparam int QUIET_LIMIT   = 3000;  // cycles with no handshake at all before giving up

  localparam bit KIND_SAMPLE = 1'b0;
  localparam bit KIND_CAL    = 1'b1;

  typedef enum logic [1:0] {PH_IDLE = 2'd0, PH_SWEEP = 2'd1, PH_DONE = 2'd2} sweep_phase_e;
  typedef enum logic [1:0] {STALL_NONE, STALL_SOME, STALL_RUNS, STALL_HEAVY} stall_mode_e;

  typedef struct packed {
    logic                     is_cal;
    logic signed [SAMP_W-1:0] re;
    logic signed [SAMP_W-1:0] im;
    logic [IDX_W-1:0]         idx;
    logic signed [COEF_W-1:0] cre;
    logic signed [COEF_W-1:0] cim;
  } cal_item_t;

  typedef struct packed {
    logic signed [RES_W-1:0] re;
    logic signed [RES_W-1:0] im;
    logic [IDX_W-1:0]        bin;
    logic                    ovf;
  } cal_result_t;

  typedef struct packed {
    cal_item_t   item;
    logic        has_want;
    cal_result_t want;
  } dir_row_t;

  localparam cal_result_t NO_RESULT = '0;

  // Directed walk with the reset bin count of four. Rows with has_want set carry an
  // expectation that is plain from the arithmetic; the others go through the predictor.
  localparam dir_row_t DIRECTED [25] = '{
    // load bins 0..3 plus the top entry: unity, zero, smallest divisor, most negative
    '{'{KIND_CAL, 16'sh0000, 16'sh0000, 6'd0, 16'sd16384, 16'sh0000}, 1'b0, NO_RESULT},
    '{'{KIND_CAL, 16'sh0000, 16'sh0000, 6'd1, 16'sh0000, 16'sh0000}, 1'b0, NO_RESULT},
    '{'{KIND_CAL, 16'sh0000, 16'sh0000, 6'd2, 16'sd1, 16'sh0000}, 1'b0, NO_RESULT},
    '{'{KIND_CAL, 16'sh0000, 16'sh0000, 6'd3, 16'sh8000, 16'sh8000}, 1'b0, NO_RESULT},
    '{'{KIND_CAL, 16'sh0000, 16'sh0000, 6'd63, 16'sh7FFF, 16'sh7FFF}, 1'b0, NO_RESULT},
    // idle marker while idle, then a sample opens the sweep at bin 0
    '{'{KIND_SAMPLE, MARK_NEG_ONE, MARK_NEG_ONE, 6'd0, 16'sh0, 16'sh0}, 1'b0, NO_RESULT},
    '{'{KIND_SAMPLE, 16'sh7FFF, 16'sh8000, 6'd0, 16'sh0, 16'sh0}, 1'b1,
      '{32'sd32767, -32'sd32768, 6'd0, 1'b0}},
    // gap marker inside the sweep, then a zero coefficient
    '{'{KIND_SAMPLE, MARK_ZERO, MARK_NEG_ONE, 6'd0, 16'sh0, 16'sh0}, 1'b0, NO_RESULT},
    '{'{KIND_SAMPLE, 16'sd100, 16'sd200, 6'd0, 16'sh0, 16'sh0}, 1'b1,
      '{32'sd0, 32'sd0, 6'd1, 1'b1}},
    '{'{KIND_SAMPLE, 16'sh8000, 16'sh7FFF, 6'd0, 16'sh0, 16'sh0}, 1'b1,
      '{-32'sd536870912, 32'sd536854528, 6'd2, 1'b0}},
    // idle marker mid-sweep acts as a gap marker
    '{'{KIND_SAMPLE, MARK_NEG_ONE, MARK_NEG_ONE, 6'd0, 16'sh0, 16'sh0}, 1'b0, NO_RESULT},
    '{'{KIND_SAMPLE, 16'sh7FFF, 16'sh7FFF, 6'd0, 16'sh0, 16'sh0}, 1'b0, NO_RESULT},
    // past the last bin: dropped, then a marker closes the sweep
    '{'{KIND_SAMPLE, -16'sd5, 16'sd7, 6'd0, 16'sh0, 16'sh0}, 1'b0, NO_RESULT},
    '{'{KIND_SAMPLE, MARK_ZERO, MARK_NEG_ONE, 6'd0, 16'sh0, 16'sh0}, 1'b0, NO_RESULT},
    // closed sweep ignores samples and gap markers until an idle marker re-arms
    '{'{KIND_SAMPLE, 16'sd1234, -16'sd4321, 6'd0, 16'sh0, 16'sh0}, 1'b0, NO_RESULT},
    '{'{KIND_SAMPLE, MARK_ZERO, MARK_NEG_ONE, 6'd0, 16'sh0, 16'sh0}, 1'b0, NO_RESULT},
    '{'{KIND_SAMPLE, MARK_NEG_ONE, MARK_NEG_ONE, 6'd0, 16'sh0, 16'sh0}, 1'b0, NO_RESULT},
    '{'{KIND_SAMPLE, MARK_NEG_ONE, MARK_NEG_ONE, 6'd0, 16'sh0, 16'sh0}, 1'b0, NO_RESULT},
    // a gap marker opens a sweep without using a bin
    '{'{KIND_SAMPLE, MARK_ZERO, MARK_NEG_ONE, 6'd0, 16'sh0, 16'sh0}, 1'b0, NO_RESULT},
    '{'{KIND_SAMPLE, 16'sh0000, 16'sh0000, 6'd0, 16'sh0, 16'sh0}, 1'b1,
      '{32'sd0, 32'sd0, 6'd0, 1'b0}},
    // coefficient write in the middle of a sweep leaves framing alone
    '{'{KIND_CAL, 16'sh0000, 16'sh0000, 6'd0, 16'sh7FFF, 16'sh8000}, 1'b0, NO_RESULT},
    '{'{KIND_SAMPLE, -16'sd1, 16'sd1, 6'd0, 16'sh0, 16'sh0}, 1'b1,
      '{32'sd0, 32'sd0, 6'd1, 1'b1}},
    '{'{KIND_SAMPLE, 16'sh8000, 16'sh0000, 6'd0, 16'sh0, 16'sh0}, 1'b1,
      '{-32'sd536870912, 32'sd0, 6'd2, 1'b0}},
    '{'{KIND_SAMPLE, 16'sh7FFF, -16'sd32767, 6'd0, 16'sh0, 16'sh0}, 1'b0, NO_RESULT},
    '{'{KIND_SAMPLE, MARK_NEG_ONE, MARK_NEG_ONE, 6'd0, 16'sh0, 16'sh0}, 1'b0, NO_RESULT}
  };

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     kind = KIND_SAMPLE;
  logic signed [SAMP_W-1:0] sample_real = '0;
  logic signed [SAMP_W-1:0] sample_imag = '0;
  logic [IDX_W-1:0]         cal_index = '0;
  logic signed [COEF_W-1:0] cal_real = '0;
  logic signed [COEF_W-1:0] cal_imag = '0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [BINS_W-1:0]        cfg_data = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [RES_W-1:0]  result_real;
  logic signed [RES_W-1:0]  result_imag;
  logic [IDX_W-1:0]         bin_number;
  logic                     overflow_flag;

  marker_framed_bin_calibrator uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .sample_real   (sample_real),
    .sample_imag   (sample_imag),
    .cal_index     (cal_index),
    .cal_real      (cal_real),
    .cal_imag      (cal_imag),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_real   (result_real),
    .result_imag   (result_imag),
    .bin_number    (bin_number),
    .overflow_flag (overflow_flag)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: a mirror of the framing, the bin count and the coefficient table.
  // bins_loaded keeps the stimulus from ever dividing by an entry that was never written.
  logic [BINS_W-1:0]        bins_setting = BINS_RESET;
  sweep_phase_e             sweep_phase = PH_IDLE;
  int                       next_bin = 0;
  logic signed [COEF_W-1:0] coef_re [TABLE_DEPTH];
  logic signed [COEF_W-1:0] coef_im [TABLE_DEPTH];
  bit                       bins_loaded [TABLE_DEPTH];

  cal_result_t pending_quotients [$];
  int          mismatch_count = 0;
  int          burst_left = 0;
  int          quiet_cycles = 0;
  stall_mode_e stall_mode = STALL_NONE;
  int          mode_left = 0;
  int          run_left = 0;

  function automatic int active_bins();
    return (bins_setting > TABLE_DEPTH) ? TABLE_DEPTH : int'(bins_setting);
  endfunction

  function automatic bit is_idle_mark(logic signed [SAMP_W-1:0] re, logic signed [SAMP_W-1:0] im);
    return re == MARK_NEG_ONE && im == MARK_NEG_ONE;
  endfunction

  function automatic bit is_marker(logic signed [SAMP_W-1:0] re, logic signed [SAMP_W-1:0] im);
    return im == MARK_NEG_ONE && (re == MARK_NEG_ONE || re == MARK_ZERO);
  endfunction

  // n * 2^14 / d, rounded half away from zero, clamped to 32 bits
  function automatic logic [RES_W-1:0] round_quotient(input longint num, input longint den,
                                                      inout bit clipped);
    longint mag;
    longint q;
    bit     neg;
    neg = num < 0;
    mag = neg ? -num : num;
    q = (mag * 32768 + den) / (2 * den);
    if (!neg && q > 64'sh7FFF_FFFF) begin
      clipped = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (neg && q > 64'sh8000_0000) begin
      clipped = 1'b1;
      return 32'h8000_0000;
    end
    q = neg ? -q : q;
    return q[RES_W-1:0];
  endfunction

  // Advance the mirror by one item. Returns 1 when the item yields a result;
  // effective is 0 for items that the block merely ignores.
  function automatic bit calibrate_step(input cal_item_t it, output cal_result_t res,
                                        output bit effective);
    longint x;
    longint y;
    longint a;
    longint b;
    longint den;
    bit     clipped;
    res = '0;
    effective = 1'b1;
    if (it.is_cal == KIND_CAL) begin
      coef_re[it.idx] = it.cre;
      coef_im[it.idx] = it.cim;
      bins_loaded[it.idx] = 1'b1;
      return 1'b0;
    end
    if (sweep_phase == PH_DONE) begin
      if (is_idle_mark(it.re, it.im)) sweep_phase = PH_IDLE;
      else effective = 1'b0;
      return 1'b0;
    end
    if (sweep_phase != PH_SWEEP) begin
      if (is_idle_mark(it.re, it.im)) begin
        effective = 1'b0;
        return 1'b0;
      end
      next_bin = 0;
      sweep_phase = PH_SWEEP;
    end
    if (is_marker(it.re, it.im)) begin
      if (next_bin >= active_bins()) sweep_phase = PH_DONE;
      return 1'b0;
    end
    if (next_bin >= active_bins()) return 1'b0;
    x = coef_re[next_bin];
    y = coef_im[next_bin];
    a = it.re;
    b = it.im;
    den = x * x + y * y;
    clipped = 1'b0;
    if (den == 0) begin
      clipped = 1'b1;
    end else begin
      res.re = round_quotient(a * x + b * y, den, clipped);
      res.im = round_quotient(b * x - a * y, den, clipped);
    end
    res.bin = next_bin[IDX_W-1:0];
    res.ovf = clipped;
    next_bin++;
    return 1'b1;
  endfunction

  // Bin whose coefficient this sample would be divided by, or -1 if none
  function automatic int bin_to_read(input cal_item_t it);
    int bin;
    if (it.is_cal == KIND_CAL || sweep_phase == PH_DONE) return -1;
    if (sweep_phase != PH_SWEEP) begin
      if (is_idle_mark(it.re, it.im)) return -1;
      bin = 0;
    end else begin
      bin = next_bin;
    end
    if (is_marker(it.re, it.im) || bin >= active_bins()) return -1;
    return bin;
  endfunction

  function automatic logic signed [SAMP_W-1:0] sample_part();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      3:       return 16'shFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_part();
    case ($urandom_range(0, 9))
      0:       return 16'sh0000;
      1:       return 16'sh8000;
      2:       return 16'sh7FFF;
      3:       return 16'(int'($urandom_range(0, 6)) - 3);
      default: return 16'($urandom);
    endcase
  endfunction

  // Random payload with every field filled; callers overwrite what matters
  function automatic cal_item_t noise_item();
    cal_item_t it;
    it.is_cal = KIND_SAMPLE;
    it.re  = sample_part();
    it.im  = sample_part();
    it.idx = IDX_W'($urandom);
    it.cre = coef_part();
    it.cim = coef_part();
    return it;
  endfunction

  function automatic cal_item_t coef_write(input int bin);
    cal_item_t it;
    it = noise_item();
    it.is_cal = KIND_CAL;
    it.idx = bin[IDX_W-1:0];
    return it;
  endfunction

  function automatic cal_item_t marker_item(input bit idle);
    cal_item_t it;
    it = noise_item();
    it.re = idle ? MARK_NEG_ONE : MARK_ZERO;
    it.im = MARK_NEG_ONE;
    return it;
  endfunction

  function automatic cal_item_t data_item();
    cal_item_t it;
    it = noise_item();
    if (is_marker(it.re, it.im)) it.im = 16'sh8001;
    return it;
  endfunction

  // Mostly well-formed framing that follows the mirror's phase, with some noise
  function automatic cal_item_t next_sweep_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return coef_write($urandom_range(0, TABLE_DEPTH - 1));
    if (r < 10) return noise_item();
    r = $urandom_range(0, 99);
    case (sweep_phase)
      PH_IDLE: begin
        if (r < 45) return marker_item(1'b1);
        if (r < 60) return marker_item(1'b0);
        return data_item();
      end
      PH_SWEEP: begin
        if (next_bin < active_bins()) begin
          if (r < 8) return marker_item(1'b0);
          if (r < 11) return marker_item(1'b1);
          return data_item();
        end
        if (r < 30) return data_item();
        return marker_item(r < 65);
      end
      default: begin
        if (r < 65) return marker_item(1'b1);
        if (r < 80) return marker_item(1'b0);
        return data_item();
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("mismatch %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
  endtask

  // Offer one item and hold it until accepted; then idle for a gap once the burst runs out.
  task automatic send_item(input cal_item_t it, input bit has_want, input cal_result_t want,
                           output bit effective);
    cal_result_t predicted;
    bit          produces;
    int          gap;
    in_valid    <= 1'b1;
    kind        <= it.is_cal;
    sample_real <= it.re;
    sample_imag <= it.im;
    cal_index   <= it.idx;
    cal_real    <= it.cre;
    cal_imag    <= it.cim;
    do @(posedge clk); while (in_stall !== 1'b0);
    produces = calibrate_step(it, predicted, effective);
    if (produces)
      pending_quotients.insert(pending_quotients.size(), has_want ? want : predicted);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // short gaps mostly, now and then long enough to cover a whole divide
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 130) : $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 10);
    end
  endtask

  // Hold the input until every quotient is back; optionally let trailing work finish.
  task automatic drain_quotients(input bit settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_quotients.size() != 0);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_bins(input logic [BINS_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    bins_setting = value;
    cfg_valid <= 1'b0;
  endtask

  // Receiver: switch at random between stall styles
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE: out_stall <= 1'b0;
        STALL_SOME: out_stall <= ($urandom_range(0, 99) < 30);
        STALL_RUNS: begin
          if (run_left == 0) begin
            out_stall <= !out_stall;
            run_left = $urandom_range(1, 40);
          end else begin
            run_left--;
          end
        end
        default: out_stall <= ($urandom_range(0, 99) < 85);
      endcase
    end
  end

  // Compare each accepted result with the oldest outstanding quotient
  always @(posedge clk) begin : check_results
    cal_result_t want;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_quotients.size() == 0) begin
        report_mismatch("result with nothing outstanding, bin", bin_number, -1);
      end else begin
        want = pending_quotients.pop_front();
        if (result_real !== want.re) report_mismatch("result_real", result_real, want.re);
        if (result_imag !== want.im) report_mismatch("result_imag", result_imag, want.im);
        if (bin_number !== want.bin) report_mismatch("bin_number", bin_number, want.bin);
        if (overflow_flag !== want.ovf)
          report_mismatch("overflow_flag", overflow_flag, want.ovf);
      end
    end
  end

  // Watchdog: any handshake on any channel counts as progress
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        (cfg_valid && cfg_ready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int          sweep_sizes [7];
    int          budget;
    int          pause_at;
    int          counted;
    int          fill_bin;
    bit          eff;
    bit          paused;
    cal_item_t   it;
    sweep_sizes = '{64, 1, 0, 127, 0, 0, 0};
    for (int i = 4; i < 7; i++) sweep_sizes[i] = $urandom_range(1, TABLE_DEPTH);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part runs with the reset bin count
    foreach (DIRECTED[i])
      send_item(DIRECTED[i].item, DIRECTED[i].has_want, DIRECTED[i].want, eff);
    drain_quotients(1'b1);

    // Random sweeps, one bin count per phase; bigger active bin counts get longer phases
    foreach (sweep_sizes[p]) begin
      write_bins(BINS_W'(sweep_sizes[p]));
      budget = 20 + 2 * active_bins();
      pause_at = $urandom_range(1, budget - 1);
      paused = 1'b0;
      counted = 0;
      while (counted < budget) begin
        if (counted == pause_at && !paused) begin
          drain_quotients(1'b0);
          paused = 1'b1;
        end
        it = next_sweep_item();
        // load the coefficient first if this sample would hit an untouched entry
        fill_bin = bin_to_read(it);
        if (fill_bin >= 0 && !bins_loaded[fill_bin]) begin
          send_item(coef_write(fill_bin), 1'b0, NO_RESULT, eff);
          counted++;
        end
        send_item(it, 1'b0, NO_RESULT, eff);
        if (eff) counted++;
      end
      drain_quotients(1'b1);
    end

    if (mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
